@@ rtl/eoip_pkg.sv @@
// Shared widths, types and codes for the exact orientation / in-circle block.
// Used by the channel interfaces and the top level.
package eoip_pkg;

    localparam int CW     = 24;              // coordinate field width
    localparam int IDX_W  = 10;              // vertex index field width
    localparam int CMD_W  = 2;
    localparam int SIDE_W = 2;

    // exact arithmetic widths
    localparam int DW     = CW + 1;          // vertex minus / plus point
    localparam int PW     = 2 * DW;          // square-ish products
    localparam int ZW     = PW + 1;          // lifted coordinate
    localparam int SPLIT  = 26;              // multiplier operand slice
    localparam int ZHI_W  = ZW - SPLIT;
    localparam int ZPLW   = DW + SPLIT + 1;  // dy * low slice of z
    localparam int ZPHW   = DW + ZHI_W;      // dy * high slice of z
    localparam int PRODW  = DW + ZW;         // dy * z
    localparam int CFW    = PRODW + 1;       // 2x2 minor
    localparam int CHI_W  = CFW - 2 * SPLIT;
    localparam int CPLW   = DW + SPLIT + 1;  // dx * low or mid slice of minor
    localparam int CPHW   = DW + CHI_W;      // dx * high slice of minor
    localparam int TERMW  = DW + CFW;        // dx * minor
    localparam int DETW   = TERMW + 2;       // sum of three terms

    typedef logic signed [CW-1:0]    t_coord;
    typedef logic signed [DW-1:0]    t_diff;
    typedef logic signed [PW-1:0]    t_prod;
    typedef logic signed [ZW-1:0]    t_lift;
    typedef logic signed [ZPLW-1:0]  t_zpp_lo;
    typedef logic signed [ZPHW-1:0]  t_zpp_hi;
    typedef logic signed [PRODW-1:0] t_dyz;
    typedef logic signed [CFW-1:0]   t_minor;
    typedef logic signed [CPLW-1:0]  t_cpp_lo;
    typedef logic signed [CPHW-1:0]  t_cpp_hi;
    typedef logic signed [TERMW-1:0] t_term;
    typedef logic signed [DETW-1:0]  t_det;
    typedef logic [SIDE_W-1:0]       t_side;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE    = 2'd0,
        CMD_ORIENT   = 2'd1,
        CMD_INCIRCLE = 2'd2
    } t_cmd;

    localparam t_side SIDE_ZERO = 2'b00;
    localparam t_side SIDE_POS  = 2'b01;
    localparam t_side SIDE_NEG  = 2'b11;

    // cofactor k = dy[NXT1[k]] * z[NXT2[k]] - dy[NXT2[k]] * z[NXT1[k]]
    localparam int NXT1 [3] = '{1, 2, 0};
    localparam int NXT2 [3] = '{2, 0, 1};

endpackage

@@ rtl/eoip_cmd_if.sv @@
// Command channel: valid/ready handshake carrying one command word.
// Depends on eoip_pkg for field widths.
interface eoip_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [eoip_pkg::CMD_W-1:0]    command;
    logic signed [eoip_pkg::CW-1:0] point_x;
    logic signed [eoip_pkg::CW-1:0] point_y;
    logic [eoip_pkg::IDX_W-1:0]    index_a;
    logic [eoip_pkg::IDX_W-1:0]    index_b;
    logic [eoip_pkg::IDX_W-1:0]    index_c;

    modport source (
        output valid, command, point_x, point_y, index_a, index_b, index_c,
        input  ready
    );
    modport sink (
        input  valid, command, point_x, point_y, index_a, index_b, index_c,
        output ready
    );
endinterface

@@ rtl/eoip_res_if.sv @@
// Result channel: valid/ready handshake carrying one side word.
// Depends on eoip_pkg for the side width.
interface eoip_res_if;
    logic                             valid;
    logic                             ready;
    logic signed [eoip_pkg::SIDE_W-1:0] side;

    modport source (output valid, side, input ready);
    modport sink   (input valid, side, output ready);
endinterface

@@ rtl/eoip_vtx_ram.sv @@
// Vertex RAM: one write port, one read port with registered read data.
// Stand-alone; no package use.
module eoip_vtx_ram #(
    parameter int DEPTH  = 1024,
    parameter int AW     = 10,
    parameter int DATA_W = 48
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);
    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

@@ rtl/exact_orient_incircle_predicates.sv @@
// Exact 2D orientation and in-circle predicates over a vertex RAM.
// Depends on eoip_pkg, eoip_cmd_if, eoip_res_if and eoip_vtx_ram.
//
// i_cmd takes one word per handshake. A write word stores (point_x, point_y)
// at index_a and returns nothing; an out-of-range address is dropped. An
// orientation word returns the sign of det(P-V0, V1-V0); an in-circle word
// returns +1 inside, -1 outside, 0 on the circle of V0, V1, V2. Command three
// is dropped. An out-of-range vertex index reads as (0, 0); an entry never
// written reads as whatever the RAM holds.
// o_res carries one side word per query, in order of acceptance.
// Throughput: one word per cycle while o_res is not stalled, set by the fully pipelined
// multiplier tree; three RAM copies give each query its three reads in the same cycle.
// A write is visible to a query accepted in the next cycle.
// A query's result passes through registers for the RAM read, differences, squares,
// lifting, a two-slice multiply and its recombination, minors, a three-slice multiply
// and its recombination, final sum and sign.
// Reset clears the pipeline valid bits only; RAM contents are undefined
// until written. When o_res is stalled, each stage holds while its
// successor is full, so bubbles drain and i_cmd stays ready while any
// stage is empty.
module exact_orient_incircle_predicates #(
    parameter int VERTEX_COUNT = 1024,
    parameter int COORD_BITS   = 24
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    eoip_cmd_if.sink   i_cmd,
    eoip_res_if.source o_res
);
    import eoip_pkg::*;

    localparam int AW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
    localparam int XW = IDX_W + AW;
    localparam int VW = 2 * COORD_BITS;
    localparam int NS = 11;

    // handshake and stage control
    logic [NS+1:1] en;
    logic [NS:1]   r_v;
    logic [NS:1]   n_v;
    logic          accept;
    logic          is_query;

    always_comb begin
        en[NS+1] = o_res.ready;
        for (int k = NS; k >= 1; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign i_cmd.ready = en[1];
    assign accept      = i_cmd.valid && en[1];
    assign is_query    = (i_cmd.command == CMD_ORIENT) || (i_cmd.command == CMD_INCIRCLE);

    always_comb begin
        n_v[1] = accept && is_query;
        for (int k = 2; k <= NS; k++) begin
            n_v[k] = r_v[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 1; k <= NS; k++) begin
                if (en[k]) begin
                    r_v[k] <= n_v[k];
                end
            end
        end
    end

    // index decode and vertex RAM copies, one per read index
    logic [IDX_W-1:0] idx     [3];
    logic [XW-1:0]    idx_x   [3];
    logic [AW-1:0]    addr    [3];
    logic             in_rng  [3];
    logic [VW-1:0]    rd_data [3];
    logic             wr_en;
    logic [VW-1:0]    wr_data;
    t_coord           pnt_x;
    t_coord           pnt_y;

    assign idx[0] = i_cmd.index_a;
    assign idx[1] = i_cmd.index_b;
    assign idx[2] = i_cmd.index_c;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            idx_x[k]  = XW'(idx[k]);
            in_rng[k] = idx_x[k] < XW'(VERTEX_COUNT);
            addr[k]   = idx_x[k][AW-1:0];
        end
    end

    assign pnt_x   = CW'($signed(i_cmd.point_x[COORD_BITS-1:0]));
    assign pnt_y   = CW'($signed(i_cmd.point_y[COORD_BITS-1:0]));
    assign wr_en   = accept && (i_cmd.command == CMD_WRITE) && in_rng[0];
    assign wr_data = {i_cmd.point_x[COORD_BITS-1:0], i_cmd.point_y[COORD_BITS-1:0]};

    for (genvar g = 0; g < 3; g++) begin : g_ram
        eoip_vtx_ram #(
            .DEPTH  (VERTEX_COUNT),
            .AW     (AW),
            .DATA_W (VW)
        ) u_ram (
            .i_clk     (i_clk),
            .i_wr_en   (wr_en),
            .i_wr_addr (addr[0]),
            .i_wr_data (wr_data),
            .i_rd_en   (n_v[1]),
            .i_rd_addr (addr[g]),
            .o_rd_data (rd_data[g])
        );
    end

    // carried along the pipe
    logic   r_incirc [1:10];
    t_side  r_side_o [4:10];
    t_diff  r_dx     [2:7][3];
    t_diff  r_dy     [2:4][3];

    // stage 1: point and range flags beside the RAM read registers
    t_coord r_s1_px;
    t_coord r_s1_py;
    logic   r_s1_rng [3];

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_incirc[1] <= i_cmd.command == CMD_INCIRCLE;
            r_s1_px     <= pnt_x;
            r_s1_py     <= pnt_y;
            for (int k = 0; k < 3; k++) begin
                r_s1_rng[k] <= in_rng[k];
            end
        end
    end

    // stage 2: vertex minus point, vertex plus point
    t_coord vx [3];
    t_coord vy [3];
    t_diff  r_s2_sx [3];
    t_diff  r_s2_sy [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            vx[k] = r_s1_rng[k] ? CW'($signed(rd_data[k][VW-1:COORD_BITS])) : '0;
            vy[k] = r_s1_rng[k] ? CW'($signed(rd_data[k][COORD_BITS-1:0])) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[2]) begin
            r_incirc[2] <= r_incirc[1];
            for (int k = 0; k < 3; k++) begin
                r_dx[2][k]  <= DW'(vx[k]) - DW'(r_s1_px);
                r_dy[2][k]  <= DW'(vy[k]) - DW'(r_s1_py);
                r_s2_sx[k]  <= DW'(vx[k]) + DW'(r_s1_px);
                r_s2_sy[k]  <= DW'(vy[k]) + DW'(r_s1_py);
            end
        end
    end

    // stage 3: squares for lifting; orientation reduces to D1x*D0y - D0x*D1y
    t_prod r_s3_sxdx [3];
    t_prod r_s3_sydy [3];
    t_prod r_s3_o1;
    t_prod r_s3_o2;

    always_ff @(posedge i_clk) begin
        if (en[3]) begin
            r_incirc[3] <= r_incirc[2];
            r_dx[3]     <= r_dx[2];
            r_dy[3]     <= r_dy[2];
            for (int k = 0; k < 3; k++) begin
                r_s3_sxdx[k] <= PW'(r_s2_sx[k]) * PW'(r_dx[2][k]);
                r_s3_sydy[k] <= PW'(r_s2_sy[k]) * PW'(r_dy[2][k]);
            end
            r_s3_o1 <= PW'(r_dx[2][1]) * PW'(r_dy[2][0]);
            r_s3_o2 <= PW'(r_dx[2][0]) * PW'(r_dy[2][1]);
        end
    end

    // stage 4: lifted coordinate and orientation sign
    t_lift r_s4_z [3];
    t_lift det_o;

    assign det_o = ZW'(r_s3_o1) - ZW'(r_s3_o2);

    always_ff @(posedge i_clk) begin
        if (en[4]) begin
            r_incirc[4] <= r_incirc[3];
            r_dx[4]     <= r_dx[3];
            r_dy[4]     <= r_dy[3];
            for (int k = 0; k < 3; k++) begin
                r_s4_z[k] <= ZW'(r_s3_sxdx[k]) + ZW'(r_s3_sydy[k]);
            end
            if (det_o == '0) begin
                r_side_o[4] <= SIDE_ZERO;
            end else if (det_o[ZW-1]) begin
                r_side_o[4] <= SIDE_NEG;
            end else begin
                r_side_o[4] <= SIDE_POS;
            end
        end
    end

    // stage 5: dy * z split in two slices of z; even product is the minuend
    t_zpp_lo r_s5_lo [6];
    t_zpp_hi r_s5_hi [6];

    always_ff @(posedge i_clk) begin
        if (en[5]) begin
            r_incirc[5] <= r_incirc[4];
            r_side_o[5] <= r_side_o[4];
            r_dx[5]     <= r_dx[4];
            for (int k = 0; k < 3; k++) begin
                r_s5_lo[2*k] <= ZPLW'(r_dy[4][NXT1[k]])
                    * ZPLW'($signed({1'b0, r_s4_z[NXT2[k]][SPLIT-1:0]}));
                r_s5_hi[2*k] <= ZPHW'(r_dy[4][NXT1[k]])
                    * ZPHW'($signed(r_s4_z[NXT2[k]][ZW-1:SPLIT]));
                r_s5_lo[2*k+1] <= ZPLW'(r_dy[4][NXT2[k]])
                    * ZPLW'($signed({1'b0, r_s4_z[NXT1[k]][SPLIT-1:0]}));
                r_s5_hi[2*k+1] <= ZPHW'(r_dy[4][NXT2[k]])
                    * ZPHW'($signed(r_s4_z[NXT1[k]][ZW-1:SPLIT]));
            end
        end
    end

    // stage 6: recombine slices
    t_dyz r_s6_p [6];

    always_ff @(posedge i_clk) begin
        if (en[6]) begin
            r_incirc[6] <= r_incirc[5];
            r_side_o[6] <= r_side_o[5];
            r_dx[6]     <= r_dx[5];
            for (int p = 0; p < 6; p++) begin
                r_s6_p[p] <= (PRODW'(r_s5_hi[p]) <<< SPLIT) + PRODW'(r_s5_lo[p]);
            end
        end
    end

    // stage 7: 2x2 minors
    t_minor r_s7_c [3];

    always_ff @(posedge i_clk) begin
        if (en[7]) begin
            r_incirc[7] <= r_incirc[6];
            r_side_o[7] <= r_side_o[6];
            r_dx[7]     <= r_dx[6];
            for (int k = 0; k < 3; k++) begin
                r_s7_c[k] <= CFW'(r_s6_p[2*k]) - CFW'(r_s6_p[2*k+1]);
            end
        end
    end

    // stage 8: dx * minor in three slices of the minor
    t_cpp_lo r_s8_lo [3];
    t_cpp_lo r_s8_mid [3];
    t_cpp_hi r_s8_hi [3];

    always_ff @(posedge i_clk) begin
        if (en[8]) begin
            r_incirc[8] <= r_incirc[7];
            r_side_o[8] <= r_side_o[7];
            for (int k = 0; k < 3; k++) begin
                r_s8_lo[k]  <= CPLW'(r_dx[7][k])
                    * CPLW'($signed({1'b0, r_s7_c[k][SPLIT-1:0]}));
                r_s8_mid[k] <= CPLW'(r_dx[7][k])
                    * CPLW'($signed({1'b0, r_s7_c[k][2*SPLIT-1:SPLIT]}));
                r_s8_hi[k]  <= CPHW'(r_dx[7][k])
                    * CPHW'($signed(r_s7_c[k][CFW-1:2*SPLIT]));
            end
        end
    end

    // stage 9: recombine slices into the three terms
    t_term r_s9_t [3];

    always_ff @(posedge i_clk) begin
        if (en[9]) begin
            r_incirc[9] <= r_incirc[8];
            r_side_o[9] <= r_side_o[8];
            for (int k = 0; k < 3; k++) begin
                r_s9_t[k] <= (TERMW'(r_s8_hi[k]) <<< (2 * SPLIT))
                    + (TERMW'(r_s8_mid[k]) <<< SPLIT) + TERMW'(r_s8_lo[k]);
            end
        end
    end

    // stage 10: determinant
    t_det r_s10_det;

    always_ff @(posedge i_clk) begin
        if (en[10]) begin
            r_incirc[10] <= r_incirc[9];
            r_side_o[10] <= r_side_o[9];
            r_s10_det    <= DETW'(r_s9_t[0]) + DETW'(r_s9_t[1]) + DETW'(r_s9_t[2]);
        end
    end

    // stage 11: output word; negative determinant means inside
    t_side r_s11_side;

    always_ff @(posedge i_clk) begin
        if (en[11]) begin
            if (!r_incirc[10]) begin
                r_s11_side <= r_side_o[10];
            end else if (r_s10_det == '0) begin
                r_s11_side <= SIDE_ZERO;
            end else if (r_s10_det[DETW-1]) begin
                r_s11_side <= SIDE_POS;
            end else begin
                r_s11_side <= SIDE_NEG;
            end
        end
    end

    assign o_res.valid = r_v[NS];
    assign o_res.side  = r_s11_side;

`ifndef ASSERT_OFF
    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result valid right after reset");

    a_query_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && is_query) |=> r_v[1])
        else $error("accepted query did not enter the pipe");

    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !is_query) |=> !r_v[1])
        else $error("write or unused command entered the pipe");

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_res.valid |-> i_cmd.ready)
        else $error("input blocked with an empty output stage");

    a_side_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.side == SIDE_POS || o_res.side == SIDE_NEG
                         || o_res.side == SIDE_ZERO))
        else $error("bad side word");
`endif
endmodule
